[rtl/core/dfsl_pkg.sv]
package dfsl_pkg;

  // vertex numbering and storage sizes
  localparam int MAX_V  = 32;
  localparam int VW     = 6;
  localparam int AW     = $clog2(MAX_V);
  localparam int ROW_W  = 32;

  // configuration register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_ROOT_VERTEX  = 1'b1;

  // write side of the adjacency store
  typedef struct packed {
    logic             en;
    logic [AW-1:0]    addr;
    logic [ROW_W-1:0] data;
    logic             clear;
  } adj_wr_t;

  // vertex 1..MAX_V to storage address
  function automatic logic [AW-1:0] vidx(input logic [VW-1:0] v);
    logic [VW-1:0] t;
    t = v - VW'(1);
    return t[AW-1:0];
  endfunction

endpackage

[rtl/core/dfsl_if.sv]
interface dfsl_row_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row_index;
  logic [31:0] row_bits;
  logic        last_row;

  modport source(output valid, row_index, row_bits, last_row, input ready);
  modport sink(input valid, row_index, row_bits, last_row, output ready);
endinterface

interface dfsl_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] vertex;
  logic       visited;
  logic [5:0] dfs_number;
  logic [5:0] parent_vertex;
  logic [5:0] low_point;
  logic       root_error;
  logic       last_result;

  modport source(output valid, vertex, visited, dfs_number, parent_vertex, low_point,
                 root_error, last_result, input ready);
  modport sink(input valid, vertex, visited, dfs_number, parent_vertex, low_point,
               root_error, last_result, output ready);
endinterface

[rtl/core/dfsl_adj_mem.sv]
module dfsl_adj_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  dfsl_pkg::adj_wr_t           wr,
  input  logic [dfsl_pkg::AW-1:0]     rd_addr,
  output logic [dfsl_pkg::ROW_W-1:0]  rd_data
);

  logic [dfsl_pkg::ROW_W-1:0] mem [dfsl_pkg::MAX_V];
  logic [dfsl_pkg::MAX_V-1:0] row_valid;

  // row storage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // per-row valid bits, a missing row reads as zero
  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

[rtl/core/dfs_number_and_lowpoint.sv]
// Depth-first numbering and lowpoints over an adjacency matrix of up to 32
// vertices. Each row item is stored as it is taken, and the last row also
// starts a run: the walk scans one candidate neighbor per cycle, with a row
// fetch on each descent and return, the lowpoint pass scans one neighbor per
// cycle (both edge directions from the single read port of the adjacency
// memory), then one result per vertex leaves per cycle while the output is
// not stalled. Rows are not taken until the last result is in the output
// register. A bad root or a zero vertex count gives a single error result.
module dfs_number_and_lowpoint (
  input  logic               clk,
  input  logic               rst,
  dfsl_row_if.sink           rows,
  dfsl_res_if.source         results,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int VW = dfsl_pkg::VW;
  localparam int AW = dfsl_pkg::AW;
  localparam int NV = dfsl_pkg::MAX_V;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_WLOAD  = 4'd2;
  localparam logic [3:0] S_WSCAN  = 4'd3;
  localparam logic [3:0] S_LSTART = 4'd4;
  localparam logic [3:0] S_LROWV  = 4'd5;
  localparam logic [3:0] S_LSCAN  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_ERR    = 4'd8;

  logic [3:0]    state;
  logic [VW-1:0] vertex_count, root_vertex;
  logic [VW-1:0] n_cfg, n_reg;

  logic [NV-1:0] explored;
  logic [VW-1:0] num_of  [NV];
  logic [VW-1:0] parent  [NV];
  logic [VW-1:0] low     [NV];
  logic [VW-1:0] von     [NV];
  logic [VW-1:0] stk_v   [NV];
  logic [VW-1:0] stk_c   [NV];

  logic [VW-1:0] sp, nxt, d, j, k, v_reg, par_reg, m;
  logic [31:0]   vrow;

  dfsl_pkg::adj_wr_t adj_wr;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       row_q;

  logic          row_acc, out_load;
  logic [AW-1:0] tidx;
  logic [VW-1:0] top_v, jn, nj, m_next;
  logic          edge_hit, run_err;

  dfsl_adj_mem u_adj (
    .clk     (clk),
    .rst     (rst),
    .wr      (adj_wr),
    .rd_addr (rd_addr),
    .rd_data (row_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VW'(32);
      root_vertex  <= VW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfsl_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data;
        dfsl_pkg::REG_ROOT_VERTEX:  root_vertex  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_cfg   = (vertex_count > VW'(NV)) ? VW'(NV) : vertex_count;
  assign run_err = (n_cfg == '0) || (root_vertex == '0) || (root_vertex > n_cfg);

  assign rows.ready = (state == S_IDLE);
  assign row_acc    = rows.valid && rows.ready;

  // stack top and next walk candidate
  always_comb begin
    logic [VW-1:0] spm1;
    spm1  = sp - VW'(1);
    tidx  = spm1[AW-1:0];
    top_v = stk_v[tidx];
    jn    = stk_c[tidx] + VW'(1);
  end

  // lowpoint candidate from neighbor j
  always_comb begin
    edge_hit = vrow[dfsl_pkg::vidx(j)] | row_q[dfsl_pkg::vidx(v_reg)];
    nj       = num_of[dfsl_pkg::vidx(j)];
    m_next   = m;
    if (edge_hit) begin
      if (nj > d) begin
        if (low[dfsl_pkg::vidx(j)] < m) m_next = low[dfsl_pkg::vidx(j)];
      end else if (par_reg != j) begin
        if (nj < m) m_next = nj;
      end
    end
  end

  // adjacency read address
  always_comb begin
    unique case (state)
      S_WLOAD, S_WSCAN: rd_addr = dfsl_pkg::vidx(top_v);
      S_LSTART:         rd_addr = dfsl_pkg::vidx(von[dfsl_pkg::vidx(d)]);
      S_LROWV:          rd_addr = '0;
      S_LSCAN:          rd_addr = dfsl_pkg::vidx(j + VW'(1));
      default:          rd_addr = '0;
    endcase
  end

  assign out_load = ((state == S_OUT) || (state == S_ERR)) &&
                    (!results.valid || results.ready);

  // adjacency writes and clear at the end of a run
  always_comb begin
    adj_wr.en    = row_acc && (rows.row_index != '0) && (rows.row_index <= VW'(NV));
    adj_wr.addr  = dfsl_pkg::vidx(rows.row_index);
    adj_wr.data  = rows.row_bits;
    adj_wr.clear = out_load && ((state == S_ERR) || (k == n_reg));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (row_acc && rows.last_row) state <= S_START;
        end
        S_START: begin
          n_reg <= n_cfg;
          if (run_err) begin
            state <= S_ERR;
          end else begin
            sp    <= VW'(1);
            nxt   <= VW'(1);
            state <= S_WLOAD;
          end
        end
        S_WLOAD: state <= S_WSCAN;
        S_WSCAN: begin
          if (jn > n_reg) begin
            sp <= sp - VW'(1);
            if (sp == VW'(1)) begin
              d     <= nxt;
              state <= S_LSTART;
            end else begin
              state <= S_WLOAD;
            end
          end else if (row_q[dfsl_pkg::vidx(jn)] && !explored[dfsl_pkg::vidx(jn)]) begin
            sp    <= sp + VW'(1);
            nxt   <= nxt + VW'(1);
            state <= S_WLOAD;
          end
        end
        S_LSTART: begin
          v_reg <= von[dfsl_pkg::vidx(d)];
          state <= S_LROWV;
        end
        S_LROWV: begin
          vrow    <= row_q;
          par_reg <= parent[dfsl_pkg::vidx(v_reg)];
          m       <= d;
          j       <= VW'(1);
          state   <= S_LSCAN;
        end
        S_LSCAN: begin
          if (j == n_reg) begin
            if (d == VW'(1)) begin
              k     <= VW'(1);
              state <= S_OUT;
            end else begin
              d     <= d - VW'(1);
              state <= S_LSTART;
            end
          end else begin
            j <= j + VW'(1);
            m <= m_next;
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (k == n_reg) state <= S_IDLE;
            else            k <= k + VW'(1);
          end
        end
        S_ERR: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-vertex tables
  always_ff @(posedge clk) begin
    if (state == S_START) begin
      for (int i = 0; i < NV; i++) begin
        explored[i] <= (AW'(i) == dfsl_pkg::vidx(root_vertex));
        num_of[i]   <= (AW'(i) == dfsl_pkg::vidx(root_vertex)) ? VW'(1) : '0;
        parent[i]   <= '0;
        low[i]      <= n_cfg + VW'(1);
      end
      von[0]   <= root_vertex;
      stk_v[0] <= root_vertex;
      stk_c[0] <= '0;
    end else if (state == S_WSCAN && jn <= n_reg) begin
      stk_c[tidx] <= jn;
      if (row_q[dfsl_pkg::vidx(jn)] && !explored[dfsl_pkg::vidx(jn)]) begin
        explored[dfsl_pkg::vidx(jn)]       <= 1'b1;
        num_of[dfsl_pkg::vidx(jn)]         <= nxt + VW'(1);
        parent[dfsl_pkg::vidx(jn)]         <= top_v;
        von[dfsl_pkg::vidx(nxt + VW'(1))]  <= jn;
        stk_v[sp[AW-1:0]]                  <= jn;
        stk_c[sp[AW-1:0]]                  <= '0;
      end
    end else if (state == S_LSCAN && j == n_reg) begin
      low[dfsl_pkg::vidx(v_reg)] <= m_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_ERR) begin
        results.vertex        <= '0;
        results.visited       <= 1'b0;
        results.dfs_number    <= '0;
        results.parent_vertex <= '0;
        results.low_point     <= '0;
        results.root_error    <= 1'b1;
        results.last_result   <= 1'b1;
      end else begin
        results.vertex        <= k;
        results.visited       <= explored[dfsl_pkg::vidx(k)];
        results.dfs_number    <= num_of[dfsl_pkg::vidx(k)];
        results.parent_vertex <= parent[dfsl_pkg::vidx(k)];
        results.low_point     <= low[dfsl_pkg::vidx(k)];
        results.root_error    <= 1'b0;
        results.last_result   <= (k == n_reg);
      end
    end
  end

  // checks
  a_walk_stack: assert property (@(posedge clk) disable iff (rst)
    (state == S_WLOAD || state == S_WSCAN) |-> (sp != '0 && sp <= n_reg))
    else $error("walk stack out of range");

  a_number_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LSTART || state == S_LSCAN) |-> (d != '0 && d <= nxt && nxt <= n_reg))
    else $error("preorder number out of range");

  a_rows_stall: assert property (@(posedge clk) disable iff (rst)
    (row_acc && rows.last_row) |=> !rows.ready)
    else $error("rows taken during a run");

endmodule
